@@ sv/eqgd_pkg.sv @@
// ----------------------------------------------------------------------------
// eqgd_pkg
// Shared constants, field widths and structs of the equirectangular distance
// core.
// ----------------------------------------------------------------------------
package eqgd_pkg;

    localparam int ANGLE_FRAC_BITS = 20;
    localparam int DIST_FRAC_BITS  = 4;

    localparam int LAT_W    = 28;
    localparam int LON_W    = 29;
    localparam int DIST_W   = 30;
    localparam int RADIUS_W = 23;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [RADIUS_W-1:0] EQUATOR_RESET = 23'd6378137;
    localparam logic [RADIUS_W-1:0] POLAR_RESET   = 23'd6356725;

    // Radians per degree in Q32, rounded to nearest.
    localparam logic [26:0] RAD_PER_DEG_Q32 =
        27'(((64'd314159265 << 32) + 64'd9000000000) / 64'd18000000000);

    localparam logic [28:0] SPAN      = 29'(90 << ANGLE_FRAC_BITS);
    localparam logic [27:0] QUARTER   = 28'(90 << ANGLE_FRAC_BITS);
    localparam logic [27:0] HALF_TURN = 28'(180 << ANGLE_FRAC_BITS);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Series terms past the twelfth are always zero in Q30 for angles up to
    // a quarter turn.
    localparam int COS_TERMS = 12;
    localparam int COS_W     = 31;
    localparam int X2_W      = 32;
    localparam int SUM_W     = 33;

    localparam int EC_W   = 33;
    localparam int DLON_W = 34;
    localparam int DLAT_W = 33;
    localparam int DXY_W  = 33;

    localparam int ROOT_STAGES = 16;
    localparam int ROOT_STEPS  = 2;

    typedef enum logic {
        REG_EQUATOR = 1'b0,
        REG_POLAR   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [RADIUS_W-1:0] equator_radius_m;
        logic [RADIUS_W-1:0] polar_radius_m;
    } t_cfg;

    typedef struct packed {
        logic [EC_W-1:0]   ec_q8;
        logic [DLON_W-1:0] dlon_rad;
        logic [DLAT_W-1:0] dlat_rad;
    } t_cos_side;

    typedef struct packed {
        logic        sat;
        logic [31:0] root;
        logic [32:0] rem;
    } t_root;

endpackage

@@ sv/equirectangular_geo_distance_core.sv @@
// ----------------------------------------------------------------------------
// equirectangular_geo_distance_core
// Throughput is one beat per cycle, set by the fully pipelined multiplier,
// cosine-series and square-root stages; the whole pipe holds while a result
// beat is stalled. Reset clears all valid bits and loads the radius registers
// with their default values.
// ----------------------------------------------------------------------------
module equirectangular_geo_distance_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [eqgd_pkg::LAT_W-1:0]  i_lat_a,
    input  logic signed [eqgd_pkg::LON_W-1:0]  i_lon_a,
    input  logic signed [eqgd_pkg::LAT_W-1:0]  i_lat_b,
    input  logic signed [eqgd_pkg::LON_W-1:0]  i_lon_b,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [eqgd_pkg::DIST_W-1:0]        o_distance,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [eqgd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [eqgd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [eqgd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import eqgd_pkg::*;

    localparam int Y_SHIFT = ANGLE_FRAC_BITS - 7;
    localparam logic [50:0] Y_BIAS = 51'(45 << (Y_SHIFT - 1));
    localparam logic [38:0] DIV45_RECIP = 39'(((64'd1 << 44) + 64'd44) / 64'd45);
    localparam int RAD_SHIFT = ANGLE_FRAC_BITS + 2;
    localparam int XY_SHIFT  = 38 - DIST_FRAC_BITS;

    t_cfg cfg;
    logic en;

    eqgd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Stage 1 inputs: differences, magnitudes and latitude fold.
    logic signed [RADIUS_W:0] rad_diff;
    logic signed [LAT_W:0]    span_off;
    logic [LAT_W-1:0]         lat_mag;
    logic signed [LON_W:0]    dlon;
    logic signed [LAT_W:0]    dlat;
    logic [RADIUS_W-1:0]      n_s1_mag_d;
    logic [LAT_W-1:0]         n_s1_mag_s;
    logic [26:0]              n_s1_ang;
    logic [LON_W:0]           n_s1_dlon;
    logic [LAT_W:0]           n_s1_dlat;

    assign rad_diff = $signed({1'b0, cfg.equator_radius_m})
                    - $signed({1'b0, cfg.polar_radius_m});
    assign span_off = $signed(SPAN) - $signed({i_lat_a[LAT_W-1], i_lat_a});
    assign lat_mag  = i_lat_a[LAT_W-1] ? LAT_W'(-i_lat_a) : LAT_W'(i_lat_a);
    assign dlon     = $signed({i_lon_b[LON_W-1], i_lon_b})
                    - $signed({i_lon_a[LON_W-1], i_lon_a});
    assign dlat     = $signed({i_lat_b[LAT_W-1], i_lat_b})
                    - $signed({i_lat_a[LAT_W-1], i_lat_a});

    assign n_s1_mag_d = rad_diff[RADIUS_W] ? RADIUS_W'(-rad_diff) : RADIUS_W'(rad_diff);
    assign n_s1_mag_s = span_off[LAT_W] ? LAT_W'(-span_off) : LAT_W'(span_off);
    assign n_s1_ang   = (lat_mag > QUARTER) ? 27'(HALF_TURN - lat_mag) : 27'(lat_mag);
    assign n_s1_dlon  = dlon[LON_W] ? (LON_W + 1)'(-dlon) : (LON_W + 1)'(dlon);
    assign n_s1_dlat  = dlat[LAT_W] ? (LAT_W + 1)'(-dlat) : (LAT_W + 1)'(dlat);

    logic                r_s1_vld;
    logic [RADIUS_W-1:0] r_s1_mag_d;
    logic [LAT_W-1:0]    r_s1_mag_s;
    logic                r_s1_neg;
    logic [26:0]         r_s1_ang;
    logic [LON_W:0]      r_s1_dlon;
    logic [LAT_W:0]      r_s1_dlat;

    logic                r_s2_vld;
    logic [50:0]         r_s2_prod_ds;
    logic [53:0]         r_s2_prod_ang;
    logic [56:0]         r_s2_prod_lon;
    logic [55:0]         r_s2_prod_lat;
    logic                r_s2_neg;

    logic                r_s3_vld;
    logic [37:0]         r_s3_y;
    logic [30:0]         r_s3_x;
    logic [DLON_W-1:0]   r_s3_dlon;
    logic [DLAT_W-1:0]   r_s3_dlat;
    logic                r_s3_neg;

    logic                r_s4_vld;
    logic [37:0]         r_s4_pp_ll;
    logic [38:0]         r_s4_pp_lh;
    logic [37:0]         r_s4_pp_hl;
    logic [38:0]         r_s4_pp_hh;
    logic [X2_W-1:0]     r_s4_x2;
    logic [DLON_W-1:0]   r_s4_dlon;
    logic [DLAT_W-1:0]   r_s4_dlat;
    logic                r_s4_neg;

    logic                r_s5_vld;
    logic [32:0]         r_s5_frac;
    logic [X2_W-1:0]     r_s5_x2;
    logic [DLON_W-1:0]   r_s5_dlon;
    logic [DLAT_W-1:0]   r_s5_dlat;
    logic                r_s5_neg;

    logic                r_s6_vld;
    logic [X2_W-1:0]     r_s6_x2;
    t_cos_side           r_s6_side;

    logic [61:0]         x_sq;
    logic [76:0]         div_sum;
    logic signed [34:0]  ec_base;
    logic signed [34:0]  ec_frac;
    logic signed [34:0]  ec_val;

    assign x_sq    = 62'(r_s3_x) * 62'(r_s3_x);
    assign div_sum = (77'(r_s4_pp_hh) << 38)
                   + ((77'(r_s4_pp_lh) + 77'(r_s4_pp_hl)) << 19)
                   + 77'(r_s4_pp_ll);
    assign ec_base = $signed({4'b0000, cfg.polar_radius_m, 8'h00});
    assign ec_frac = $signed({2'b00, r_s5_frac});
    assign ec_val  = r_s5_neg ? ec_base - ec_frac : ec_base + ec_frac;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_mag_d    <= n_s1_mag_d;
            r_s1_mag_s    <= n_s1_mag_s;
            r_s1_neg      <= rad_diff[RADIUS_W] ^ span_off[LAT_W];
            r_s1_ang      <= n_s1_ang;
            r_s1_dlon     <= n_s1_dlon;
            r_s1_dlat     <= n_s1_dlat;

            r_s2_prod_ds  <= 51'(r_s1_mag_d) * 51'(r_s1_mag_s);
            r_s2_prod_ang <= 54'(r_s1_ang) * 54'(RAD_PER_DEG_Q32);
            r_s2_prod_lon <= 57'(r_s1_dlon) * 57'(RAD_PER_DEG_Q32);
            r_s2_prod_lat <= 56'(r_s1_dlat) * 56'(RAD_PER_DEG_Q32);
            r_s2_neg      <= r_s1_neg;

            r_s3_y        <= 38'((r_s2_prod_ds + Y_BIAS) >> Y_SHIFT);
            r_s3_x        <= 31'((r_s2_prod_ang + (54'd1 << (RAD_SHIFT - 1))) >> RAD_SHIFT);
            r_s3_dlon     <= DLON_W'((r_s2_prod_lon + (57'd1 << (RAD_SHIFT - 1))) >> RAD_SHIFT);
            r_s3_dlat     <= DLAT_W'((r_s2_prod_lat + (56'd1 << (RAD_SHIFT - 1))) >> RAD_SHIFT);
            r_s3_neg      <= r_s2_neg;

            r_s4_pp_ll    <= 38'(r_s3_y[18:0]) * 38'(DIV45_RECIP[18:0]);
            r_s4_pp_lh    <= 39'(r_s3_y[18:0]) * 39'(DIV45_RECIP[38:19]);
            r_s4_pp_hl    <= 38'(r_s3_y[37:19]) * 38'(DIV45_RECIP[18:0]);
            r_s4_pp_hh    <= 39'(r_s3_y[37:19]) * 39'(DIV45_RECIP[38:19]);
            r_s4_x2       <= X2_W'((x_sq + 62'd536870912) >> 30);
            r_s4_dlon     <= r_s3_dlon;
            r_s4_dlat     <= r_s3_dlat;
            r_s4_neg      <= r_s3_neg;

            r_s5_frac     <= 33'(div_sum >> 44);
            r_s5_x2       <= r_s4_x2;
            r_s5_dlon     <= r_s4_dlon;
            r_s5_dlat     <= r_s4_dlat;
            r_s5_neg      <= r_s4_neg;

            r_s6_x2             <= r_s5_x2;
            r_s6_side.ec_q8     <= ec_val[34] ? EC_W'(-ec_val) : EC_W'(ec_val);
            r_s6_side.dlon_rad  <= r_s5_dlon;
            r_s6_side.dlat_rad  <= r_s5_dlat;
        end
    end

    logic             cos_vld;
    logic [COS_W-1:0] cos_val;
    t_cos_side        cos_side;

    eqgd_cos u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s6_vld),
        .i_x2    (r_s6_x2),
        .i_side  (r_s6_side),
        .o_valid (cos_vld),
        .o_cos   (cos_val),
        .o_side  (cos_side)
    );

    logic               r_s7_vld;
    logic [EC_W-1:0]    r_s7_ed;
    logic [EC_W-1:0]    r_s7_ec;
    logic [DLON_W-1:0]  r_s7_dlon;
    logic [DLAT_W-1:0]  r_s7_dlat;

    logic               r_s8_vld;
    logic [DXY_W-1:0]   r_s8_dx;
    logic [DXY_W-1:0]   r_s8_dy;

    logic               r_s9_vld;
    logic               r_s9_sat;
    logic [62:0]        r_s9_sum;

    logic [63:0]        ed_prod;
    logic [66:0]        dx_prod;
    logic [65:0]        dy_prod;

    assign ed_prod = 64'(cos_side.ec_q8) * 64'(cos_val);
    assign dx_prod = 67'(r_s7_dlon) * 67'(r_s7_ed);
    assign dy_prod = 66'(r_s7_dlat) * 66'(r_s7_ec);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_ed   <= EC_W'((ed_prod + 64'd536870912) >> 30);
            r_s7_ec   <= cos_side.ec_q8;
            r_s7_dlon <= cos_side.dlon_rad;
            r_s7_dlat <= cos_side.dlat_rad;

            r_s8_dx   <= DXY_W'((dx_prod + (67'd1 << (XY_SHIFT - 1))) >> XY_SHIFT);
            r_s8_dy   <= DXY_W'((dy_prod + (66'd1 << (XY_SHIFT - 1))) >> XY_SHIFT);

            r_s9_sat  <= (|r_s8_dx[DXY_W-1:31]) || (|r_s8_dy[DXY_W-1:31]);
            r_s9_sum  <= 63'(62'(r_s8_dx[30:0]) * 62'(r_s8_dx[30:0]))
                       + 63'(62'(r_s8_dy[30:0]) * 62'(r_s8_dy[30:0]));
        end
    end

    logic  root_vld;
    t_root root_res;

    eqgd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s9_vld),
        .i_sat   (r_s9_sat),
        .i_sum   (r_s9_sum),
        .o_valid (root_vld),
        .o_res   (root_res)
    );

    logic              r_out_vld;
    logic [DIST_W-1:0] r_distance;
    logic [32:0]       rounded;
    logic [DIST_W-1:0] n_distance;

    assign rounded = {1'b0, root_res.root}
                   + 33'(root_res.rem > {1'b0, root_res.root});

    always_comb begin
        if (root_res.sat || (rounded > 33'(DIST_MAX))) begin
            n_distance = DIST_MAX;
        end else begin
            n_distance = rounded[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_distance <= n_distance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld  <= i_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= cos_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_out_vld <= root_vld;
        end
    end

    assign en         = !(r_out_vld && i_stall);
    assign o_stall    = !en;
    assign o_valid    = r_out_vld;
    assign o_distance = r_distance;

endmodule

@@ sv/eqgd_regs.sv @@
// ----------------------------------------------------------------------------
// eqgd_regs
// APB register file holding the equatorial and polar radius.
// ----------------------------------------------------------------------------
module eqgd_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [eqgd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [eqgd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [eqgd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output eqgd_pkg::t_cfg                     o_cfg
);
    import eqgd_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx sel;

    assign sel    = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite && pready) begin
            unique case (sel)
                REG_EQUATOR: n_cfg.equator_radius_m = pwdata[RADIUS_W-1:0];
                REG_POLAR:   n_cfg.polar_radius_m   = pwdata[RADIUS_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_EQUATOR: prdata = {{(APB_DATA_W-RADIUS_W){1'b0}}, r_cfg.equator_radius_m};
            REG_POLAR:   prdata = {{(APB_DATA_W-RADIUS_W){1'b0}}, r_cfg.polar_radius_m};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.equator_radius_m <= EQUATOR_RESET;
            r_cfg.polar_radius_m   <= POLAR_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ sv/eqgd_cos.sv @@
// ----------------------------------------------------------------------------
// eqgd_cos
// Pipelined cosine series, two stages per term: a Q30 product with x^2 and
// a division by the term's constant through a reciprocal product.
// ----------------------------------------------------------------------------
module eqgd_cos (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [eqgd_pkg::X2_W-1:0]     i_x2,
    input  eqgd_pkg::t_cos_side           i_side,
    output logic                          o_valid,
    output logic [eqgd_pkg::COS_W-1:0]    o_cos,
    output eqgd_pkg::t_cos_side           o_side
);
    import eqgd_pkg::*;

    localparam logic [COS_W-1:0] ONE_Q30 = 31'h4000_0000;

    logic                    vld_q  [0:COS_TERMS];
    logic [COS_W-1:0]        term_q [0:COS_TERMS];
    logic signed [SUM_W-1:0] sum_q  [0:COS_TERMS];
    logic [X2_W-1:0]         x2_q   [0:COS_TERMS];
    t_cos_side               side_q [0:COS_TERMS];

    assign vld_q[0]  = i_valid;
    assign term_q[0] = ONE_Q30;
    assign sum_q[0]  = $signed({2'b00, ONE_Q30});
    assign x2_q[0]   = i_x2;
    assign side_q[0] = i_side;

    for (genvar k = 1; k <= COS_TERMS; k++) begin : g_term
        localparam longint unsigned DIVISOR = (2 * k - 1) * (2 * k);
        localparam int SHIFT = 32 + $clog2(DIVISOR);
        localparam logic [32:0] RECIP =
            33'(((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR);
        localparam bit SUBTRACT = (k % 2) == 1;

        logic                    r_vld_a;
        logic [X2_W-1:0]         r_prod_a;
        logic signed [SUM_W-1:0] r_sum_a;
        logic [X2_W-1:0]         r_x2_a;
        t_cos_side               r_side_a;
        logic                    r_vld_b;
        logic [COS_W-1:0]        r_term_b;
        logic signed [SUM_W-1:0] r_sum_b;
        logic [X2_W-1:0]         r_x2_b;
        t_cos_side               r_side_b;

        logic [62:0]             mul_a;
        logic [64:0]             mul_b;
        logic [COS_W-1:0]        quot;
        logic signed [SUM_W-1:0] n_sum;

        assign mul_a = 63'(term_q[k-1]) * 63'(x2_q[k-1]);
        assign mul_b = 65'(r_prod_a) * 65'(RECIP);
        assign quot  = COS_W'(mul_b >> SHIFT);
        assign n_sum = SUBTRACT ? r_sum_a - $signed({2'b00, quot})
                                : r_sum_a + $signed({2'b00, quot});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_a <= 1'b0;
                r_vld_b <= 1'b0;
            end else if (i_en) begin
                r_vld_a <= vld_q[k-1];
                r_vld_b <= r_vld_a;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod_a <= X2_W'((mul_a + 63'd536870912) >> 30);
                r_sum_a  <= sum_q[k-1];
                r_x2_a   <= x2_q[k-1];
                r_side_a <= side_q[k-1];
                r_term_b <= quot;
                r_sum_b  <= n_sum;
                r_x2_b   <= r_x2_a;
                r_side_b <= r_side_a;
            end
        end

        assign vld_q[k]  = r_vld_b;
        assign term_q[k] = r_term_b;
        assign sum_q[k]  = r_sum_b;
        assign x2_q[k]   = r_x2_b;
        assign side_q[k] = r_side_b;
    end

    always_comb begin
        if (sum_q[COS_TERMS][SUM_W-1]) begin
            o_cos = '0;
        end else if (sum_q[COS_TERMS] > $signed({2'b00, ONE_Q30})) begin
            o_cos = ONE_Q30;
        end else begin
            o_cos = sum_q[COS_TERMS][COS_W-1:0];
        end
    end

    assign o_valid = vld_q[COS_TERMS];
    assign o_side  = side_q[COS_TERMS];

endmodule

@@ sv/eqgd_isqrt.sv @@
// ----------------------------------------------------------------------------
// eqgd_isqrt
// Pipelined bitwise integer square root with remainder, two result bits per
// stage.
// ----------------------------------------------------------------------------
module eqgd_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_sat,
    input  logic [62:0]       i_sum,
    output logic              o_valid,
    output eqgd_pkg::t_root   o_res
);
    import eqgd_pkg::*;

    logic        vld_q  [0:ROOT_STAGES];
    logic        sat_q  [0:ROOT_STAGES];
    logic [63:0] rem_q  [0:ROOT_STAGES];
    logic [63:0] root_q [0:ROOT_STAGES];

    assign vld_q[0]  = i_valid;
    assign sat_q[0]  = i_sat;
    assign rem_q[0]  = {1'b0, i_sum};
    assign root_q[0] = '0;

    for (genvar t = 0; t < ROOT_STAGES; t++) begin : g_stage
        logic        r_vld;
        logic        r_sat;
        logic [63:0] r_rem;
        logic [63:0] r_root;
        logic [63:0] n_rem;
        logic [63:0] n_root;

        always_comb begin : p_step
            logic [63:0] bitv;
            logic [63:0] trial;
            n_rem  = rem_q[t];
            n_root = root_q[t];
            for (int j = 0; j < ROOT_STEPS; j++) begin
                bitv  = 64'd1 << (62 - 2 * (ROOT_STEPS * t + j));
                trial = n_root + bitv;
                if (n_rem >= trial) begin
                    n_rem  = n_rem - trial;
                    n_root = (n_root >> 1) + bitv;
                end else begin
                    n_root = n_root >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= vld_q[t];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sat  <= sat_q[t];
                r_rem  <= n_rem;
                r_root <= n_root;
            end
        end

        assign vld_q[t+1]  = r_vld;
        assign sat_q[t+1]  = r_sat;
        assign rem_q[t+1]  = r_rem;
        assign root_q[t+1] = r_root;
    end

    assign o_valid    = vld_q[ROOT_STAGES];
    assign o_res.sat  = sat_q[ROOT_STAGES];
    assign o_res.root = root_q[ROOT_STAGES][31:0];
    assign o_res.rem  = rem_q[ROOT_STAGES][32:0];

endmodule
